// File: hw/rtl/bpa_pkg.sv
`default_nettype none

package bpa_pkg;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;
  localparam logic [1:0] STAT_FREE  = 2'd3;

  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_BASE   = 1'b1;

  localparam int COUNT_W = 5;
  localparam int ADDR_W  = 32;
  localparam int ACT_W   = 13;
  // running total of free bits found: below the count plus one byte
  localparam int GOT_W   = 6;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_AFETCH,
    S_ABIT,
    S_RCHK,
    S_CLR,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/bitmap_pool_allocator.sv
// Release reads the entry's bitmap byte, then clears its bit; clear zeroes every bitmap byte.
// Allocate: a count walk over the bitmap bytes, then a claim walk that fetches a byte and claims
// its free entries one by one, each walk over at most ceil(min(active_entries,POOL_SIZE)/8) bytes.
// One request at a time; in_tready is high only between requests.
// Reset: synchronous; a sweep over ceil(POOL_SIZE/8) bytes (512 by default) zeroes
// the bitmap memory before the first request is taken. Config writes are always taken.
`default_nettype none

module bitmap_pool_allocator #(
  parameter int POOL_SIZE = 4096,
  parameter int MAX_RUN   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // count[4:0], address[36:5], zero pad
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // entry_address[31:0]
  output logic             out_tlast,
  output logic [1:0]       out_tuser,  // status[1:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int MAP_BYTES = (POOL_SIZE + 7) / 8;
  localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int NW        = $clog2(POOL_SIZE + 1);
  localparam int ACT_RST   = ((POOL_SIZE % 8192) == 0) ? 8191 : (POOL_SIZE % 8192);

  bpa_pkg::state_t state_r, state_nxt;

  logic [7:0]                 map_mem [MAP_BYTES];
  logic [7:0]                 rd_q_r;
  logic                       mem_we;
  logic [7:0]                 mem_wdata;

  logic [AW-1:0]              ptr_r, ptr_nxt;
  logic [bpa_pkg::COUNT_W-1:0] need_r, need_nxt;
  logic [bpa_pkg::GOT_W-1:0]  got_r, got_nxt;
  logic [7:0]                 work_r, work_nxt;
  logic [2:0]                 rel_bit_r, rel_bit_nxt;
  logic [NW-1:0]              free_cnt_r, free_cnt_nxt;
  logic [31:0]                res_addr_r, res_addr_nxt;
  logic [1:0]                 res_st_r, res_st_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [31:0]                out_addr_r, out_addr_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [1:0]                 out_st_r, out_st_nxt;

  logic [bpa_pkg::ACT_W-1:0]  active_r;
  logic [31:0]                base_r;

  logic [1:0]                 req_kind;
  logic [bpa_pkg::COUNT_W-1:0] req_count;
  logic [31:0]                req_addr;
  logic [31:0]                live32;
  logic [31:0]                rel_idx;
  logic [7:0]                 range_m;
  logic                       last_byte;
  logic                       out_free;
  logic [7:0]                 scan_free;
  logic [7:0]                 bit_free;
  logic [bpa_pkg::GOT_W-1:0]  got_sum;
  logic [2:0]                 sel;
  logic [7:0]                 work_set;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(v[i]);
    end
    return c;
  endfunction

  function automatic logic [2:0] low8(input logic [7:0] v);
    logic [2:0] s;
    s = '0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) begin
        s = 3'(i);
      end
    end
    return s;
  endfunction

  assign req_kind  = in_tuser;
  assign req_count = in_tdata[4:0];
  assign req_addr  = in_tdata[36:5];

  assign live32    = (32'(active_r) > 32'(POOL_SIZE)) ? 32'(POOL_SIZE) : 32'(active_r);
  assign rel_idx   = req_addr - base_r;
  assign last_byte = (32'({ptr_r, 3'b000}) + 32'd8) >= live32;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      range_m[b] = 32'({ptr_r, 3'(b)}) < live32;
    end
  end

  assign scan_free = ~rd_q_r & range_m;
  assign bit_free  = ~work_r & range_m;
  assign got_sum   = got_r + bpa_pkg::GOT_W'(pop8(scan_free));
  assign sel       = low8(bit_free);
  assign work_set  = work_r | (8'd1 << sel);

  assign in_tready  = (state_r == bpa_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_st_r;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    need_nxt      = need_r;
    got_nxt       = got_r;
    work_nxt      = work_r;
    rel_bit_nxt   = rel_bit_r;
    free_cnt_nxt  = free_cnt_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_addr_nxt  = out_addr_r;
    out_last_nxt  = out_last_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_wdata     = '0;

    unique case (state_r)
      bpa_pkg::S_INIT, bpa_pkg::S_CLR: begin
        mem_we = 1'b1;
        if (ptr_r == AW'(MAP_BYTES - 1)) begin
          if (state_r == bpa_pkg::S_CLR) begin
            free_cnt_nxt = NW'(live32);
            res_addr_nxt = '0;
            res_st_nxt   = bpa_pkg::STAT_OK;
            state_nxt    = bpa_pkg::S_EMIT;
          end else begin
            state_nxt = bpa_pkg::S_IDLE;
          end
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      bpa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          res_addr_nxt = '0;
          unique case (req_kind)
            bpa_pkg::KIND_ALLOC: begin
              need_nxt = req_count;
              got_nxt  = '0;
              if (req_count == '0 || 32'(req_count) > 32'(MAX_RUN)) begin
                res_st_nxt = bpa_pkg::STAT_BAD;
                state_nxt  = bpa_pkg::S_EMIT;
              end else if (32'(req_count) > 32'(free_cnt_r) || live32 == '0) begin
                res_st_nxt = bpa_pkg::STAT_SHORT;
                state_nxt  = bpa_pkg::S_EMIT;
              end else begin
                ptr_nxt   = '0;
                state_nxt = bpa_pkg::S_SCAN;
              end
            end
            bpa_pkg::KIND_RELEASE: begin
              res_addr_nxt = req_addr;
              if (rel_idx >= live32) begin
                res_st_nxt = bpa_pkg::STAT_BAD;
                state_nxt  = bpa_pkg::S_EMIT;
              end else begin
                ptr_nxt     = rel_idx[AW+2:3];
                rel_bit_nxt = rel_idx[2:0];
                state_nxt   = bpa_pkg::S_RCHK;
              end
            end
            bpa_pkg::KIND_CLEAR: begin
              ptr_nxt   = '0;
              state_nxt = bpa_pkg::S_CLR;
            end
            default: begin
              res_st_nxt = bpa_pkg::STAT_BAD;
              state_nxt  = bpa_pkg::S_EMIT;
            end
          endcase
        end
      end

      bpa_pkg::S_SCAN: begin
        if (got_sum >= bpa_pkg::GOT_W'(need_r)) begin
          ptr_nxt   = '0;
          state_nxt = bpa_pkg::S_AFETCH;
        end else if (last_byte) begin
          res_addr_nxt = '0;
          res_st_nxt   = bpa_pkg::STAT_SHORT;
          state_nxt    = bpa_pkg::S_EMIT;
        end else begin
          got_nxt = got_sum;
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      bpa_pkg::S_AFETCH: begin
        work_nxt  = rd_q_r;
        state_nxt = bpa_pkg::S_ABIT;
      end

      bpa_pkg::S_ABIT: begin
        if (bit_free == '0) begin
          mem_we    = 1'b1;
          mem_wdata = work_r;
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = bpa_pkg::S_AFETCH;
        end else if (out_free) begin
          work_nxt      = work_set;
          out_valid_nxt = 1'b1;
          out_addr_nxt  = base_r + 32'({ptr_r, sel});
          out_last_nxt  = (need_r == bpa_pkg::COUNT_W'(1));
          out_st_nxt    = bpa_pkg::STAT_OK;
          free_cnt_nxt  = free_cnt_r - NW'(1);
          need_nxt      = need_r - bpa_pkg::COUNT_W'(1);
          if (need_r == bpa_pkg::COUNT_W'(1)) begin
            mem_we    = 1'b1;
            mem_wdata = work_set;
            state_nxt = bpa_pkg::S_IDLE;
          end
        end
      end

      bpa_pkg::S_RCHK: begin
        if (!rd_q_r[rel_bit_r]) begin
          res_st_nxt = bpa_pkg::STAT_FREE;
        end else begin
          mem_we     = 1'b1;
          mem_wdata  = rd_q_r & ~(8'd1 << rel_bit_r);
          res_st_nxt = bpa_pkg::STAT_OK;
          if (32'(free_cnt_r) < 32'(POOL_SIZE)) begin
            free_cnt_nxt = free_cnt_r + NW'(1);
          end
        end
        state_nxt = bpa_pkg::S_EMIT;
      end

      bpa_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_last_nxt  = 1'b1;
          out_st_nxt    = res_st_r;
          state_nxt     = bpa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bpa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[ptr_r] <= mem_wdata;
    end
    rd_q_r <= map_mem[ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_INIT;
      ptr_r       <= '0;
      free_cnt_r  <= NW'(POOL_SIZE);
      out_valid_r <= 1'b0;
      active_r    <= bpa_pkg::ACT_W'(ACT_RST);
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      free_cnt_r  <= free_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bpa_pkg::REG_ACTIVE) begin
          active_r <= cfg_data[bpa_pkg::ACT_W-1:0];
        end else begin
          base_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    need_r     <= need_nxt;
    got_r      <= got_nxt;
    work_r     <= work_nxt;
    rel_bit_r  <= rel_bit_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_last_r <= out_last_nxt;
    out_st_r   <= out_st_nxt;
  end

  a_free_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_cnt_r) <= 32'(POOL_SIZE))
    else $error("free count above pool size");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r != bpa_pkg::S_IDLE && state_r != bpa_pkg::S_EMIT)
    else $error("bitmap write outside a request");

  a_need_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpa_pkg::S_ABIT || state_r == bpa_pkg::S_AFETCH |-> need_r != '0)
    else $error("claim phase with nothing left to claim");

  a_emit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpa_pkg::S_ABIT && bit_free != '0 && out_free |=>
      out_tvalid && out_tuser == bpa_pkg::STAT_OK)
    else $error("claimed entry not presented");

endmodule

`default_nettype wire

// File: verif/bpa_tb_pkg.sv
package bpa_tb_pkg;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

endpackage

// File: verif/bitmap_pool_allocator_chk.sv
module bitmap_pool_allocator_chk #(
  parameter int POOL_SIZE = 4096,
  parameter int MAX_RUN   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [31:0] entry_address;
    logic        last;
    logic [1:0]  status;
  } pool_result_t;

  logic [POOL_SIZE-1:0] used_map;
  int unsigned          free_entries;
  logic [12:0]          active_reg;
  logic [31:0]          base_reg;
  pool_result_t         due_results[$];

  function automatic int unsigned live_count();
    return (active_reg > POOL_SIZE) ? POOL_SIZE : active_reg;
  endfunction

  function automatic void push_result(logic [31:0] addr, logic last, logic [1:0] status);
    pool_result_t r;
    r.entry_address = addr;
    r.last          = last;
    r.status        = status;
    due_results.insert(due_results.size(), r);
  endfunction

  function automatic void predict_request(logic [1:0] kind, logic [4:0] count,
                                          logic [31:0] address);
    int unsigned n;
    logic [31:0] idx;
    int unsigned picks[$];
    n = live_count();
    case (kind)
      bpa_pkg::KIND_ALLOC: begin
        if (count == 0 || count > MAX_RUN) begin
          push_result('0, 1'b1, bpa_pkg::STAT_BAD);
        end else if (count > free_entries) begin
          push_result('0, 1'b1, bpa_pkg::STAT_SHORT);
        end else begin
          for (int i = 0; i < n && picks.size() < count; i++) begin
            if (!used_map[i]) picks.insert(picks.size(), i);
          end
          if (picks.size() < count) begin
            push_result('0, 1'b1, bpa_pkg::STAT_SHORT);
          end else begin
            foreach (picks[k]) begin
              used_map[picks[k]] = 1'b1;
              push_result(base_reg + picks[k], k == count - 1, bpa_pkg::STAT_OK);
            end
            free_entries -= count;
          end
        end
      end
      bpa_pkg::KIND_RELEASE: begin
        idx = address - base_reg;
        if (idx >= n) begin
          push_result(address, 1'b1, bpa_pkg::STAT_BAD);
        end else if (!used_map[idx]) begin
          push_result(address, 1'b1, bpa_pkg::STAT_FREE);
        end else begin
          used_map[idx] = 1'b0;
          if (free_entries < POOL_SIZE) free_entries++;
          push_result(address, 1'b1, bpa_pkg::STAT_OK);
        end
      end
      bpa_pkg::KIND_CLEAR: begin
        used_map     = '0;
        free_entries = n;
        push_result('0, 1'b1, bpa_pkg::STAT_OK);
      end
      default: begin
        push_result('0, 1'b1, bpa_pkg::STAT_BAD);
      end
    endcase
  endfunction

  function automatic void check_result();
    pool_result_t want;
    if (due_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: addr %h last %b status %0d",
                 out_tdata, out_tlast, out_tuser);
      return;
    end
    want = due_results.pop_front();
    if (want.entry_address !== out_tdata || want.last !== out_tlast ||
        want.status !== out_tuser) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result mismatch: expected addr %h last %b status %0d,",
                  " got addr %h last %b status %0d"},
                 want.entry_address, want.last, want.status,
                 out_tdata, out_tlast, out_tuser);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      used_map     = '0;
      free_entries = POOL_SIZE;
      active_reg   = 13'(POOL_SIZE);
      base_reg     = '0;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bpa_pkg::REG_ACTIVE) active_reg = cfg_data[12:0];
        else base_reg = cfg_data;
      end
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata[4:0], in_tdata[36:5]);
    end
    outstanding = due_results.size();
  end

endmodule

// File: verif/bitmap_pool_allocator_tb.sv
module bitmap_pool_allocator_tb;

  localparam int POOL_SIZE    = 4096;
  localparam int MAX_RUN      = 16;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int HOLD_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  int          chk_mismatches;
  int          chk_outstanding;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_left;
  bit          hold_go;
  int          cycle_count;
  logic [12:0] cur_active;
  logic [31:0] cur_base;

  always #2 clk = ~clk;

  bitmap_pool_allocator #(.POOL_SIZE(POOL_SIZE), .MAX_RUN(MAX_RUN)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bitmap_pool_allocator_chk #(.POOL_SIZE(POOL_SIZE), .MAX_RUN(MAX_RUN)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(chk_mismatches), .outstanding(chk_outstanding)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitmap_pool_allocator regression: fail");
      $finish;
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [1:0] kind, logic [4:0] count, logic [31:0] address);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {3'b000, address, count};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (chk_outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == bpa_pkg::REG_ACTIVE) cur_active = data[12:0];
    else cur_base = data;
  endtask

  task automatic set_pool(logic [12:0] active, logic [31:0] base);
    wait_idle();
    write_reg(bpa_pkg::REG_ACTIVE, {19'b0, active});
    write_reg(bpa_pkg::REG_BASE, base);
  endtask

  task automatic random_request();
    int          r;
    int unsigned live;
    int unsigned span;
    logic [1:0]  k;
    logic [4:0]  c;
    logic [31:0] a;
    live = (cur_active > POOL_SIZE) ? POOL_SIZE : cur_active;
    span = (live == 0) ? 1 : ((live > 256) ? 256 : live);
    a    = $urandom;
    c    = ($urandom_range(99) < 30) ? 5'($urandom_range(5, 16)) : 5'($urandom_range(1, 4));
    r    = $urandom_range(99);
    if (r < 48) begin
      k = bpa_pkg::KIND_ALLOC;
    end else if (r < 90) begin
      k = bpa_pkg::KIND_RELEASE;
      c = 5'($urandom_range(0, 31));
      r = $urandom_range(99);
      if (r < 85) a = cur_base + $urandom_range(0, span - 1);
      else if (r < 95) a = cur_base + live + $urandom_range(0, 3);
    end else if (r < 93) begin
      k = bpa_pkg::KIND_CLEAR;
      c = 5'($urandom_range(0, 31));
    end else if (r < 96) begin
      k = bpa_pkg::KIND_ALLOC;
      c = $urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31));
    end else begin
      k = bpa_tb_pkg::KIND_UNUSED;
      c = 5'($urandom_range(0, 31));
    end
    send_request(k, c, a);
  endtask

  task automatic run_requests(int n);
    repeat (n) random_request();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = bpa_pkg::KIND_ALLOC;
    cfg_valid     = 1'b0;
    cfg_index     = bpa_pkg::REG_ACTIVE;
    cfg_data      = '0;
    send_idle_pct = 31;
    recv_idle_pct = 65;
    hold_go       = 1'b0;
    hold_left     = 0;
    cur_active    = 13'(POOL_SIZE);
    cur_base      = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_request(bpa_pkg::KIND_ALLOC, 5'd0, $urandom);
    send_request(bpa_pkg::KIND_ALLOC, 5'd17, $urandom);
    send_request(bpa_pkg::KIND_ALLOC, 5'd31, $urandom);
    send_request(bpa_pkg::KIND_ALLOC, 5'd1, $urandom);
    send_request(bpa_pkg::KIND_ALLOC, 5'd16, $urandom);
    send_request(bpa_pkg::KIND_RELEASE, 5'd0, 32'd0);
    send_request(bpa_pkg::KIND_RELEASE, 5'd0, 32'd0);
    send_request(bpa_pkg::KIND_RELEASE, 5'd0, 32'd4096);
    send_request(bpa_pkg::KIND_RELEASE, 5'd31, 32'hFFFF_FFFF);
    send_request(bpa_tb_pkg::KIND_UNUSED, 5'd31, 32'hFFFF_FFFF);
    send_request(bpa_pkg::KIND_CLEAR, 5'd0, 32'd0);

    set_pool(13'd8, 32'hFFFF_FFFC);
    send_request(bpa_pkg::KIND_ALLOC, 5'd8, 32'd0);
    send_request(bpa_pkg::KIND_ALLOC, 5'd1, 32'd0);
    send_request(bpa_pkg::KIND_RELEASE, 5'd0, 32'd3);
    send_request(bpa_pkg::KIND_ALLOC, 5'd2, 32'd0);
    send_request(bpa_pkg::KIND_CLEAR, 5'd0, 32'd0);
    send_request(bpa_pkg::KIND_ALLOC, 5'd9, 32'd0);
    send_request(bpa_pkg::KIND_ALLOC, 5'd8, 32'd0);
    send_request(bpa_pkg::KIND_RELEASE, 5'd0, 32'd4);

    set_pool(13'd0, 32'd0);
    send_request(bpa_pkg::KIND_ALLOC, 5'd1, 32'd0);
    send_request(bpa_pkg::KIND_CLEAR, 5'd0, 32'd0);
    send_request(bpa_pkg::KIND_ALLOC, 5'd1, 32'd0);
    send_request(bpa_pkg::KIND_RELEASE, 5'd0, 32'd0);

    set_pool(13'd8191, 32'h1234_5678);
    send_request(bpa_pkg::KIND_CLEAR, 5'd0, 32'd0);
    send_request(bpa_pkg::KIND_ALLOC, 5'd16, 32'd0);
    send_request(bpa_pkg::KIND_RELEASE, 5'd0, 32'h1234_5678 + 32'd4095);
    send_request(bpa_pkg::KIND_RELEASE, 5'd0, 32'h1234_5678 + 32'd4096);

    set_pool(13'd48, $urandom);
    run_requests(80);
    hold_go = 1'b1;
    run_requests(30);
    run_requests(40);
    set_pool(13'd4096, 32'hFFFF_FF00);
    run_requests(40);

    send_idle_pct = 65;
    recv_idle_pct = 31;
    set_pool(13'd1, $urandom);
    run_requests(20);
    set_pool(13'd0, $urandom);
    run_requests(10);
    set_pool(13'd8191, $urandom);
    run_requests(30);
    set_pool(13'd100, $urandom);
    run_requests(80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_pool(13'd16, $urandom);
    run_requests(40);
    set_pool(13'd300, $urandom);
    run_requests(80);

    in_tvalid = 1'b0;
    while (chk_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (chk_mismatches == 0 && chk_outstanding == 0) begin
      $display("bitmap_pool_allocator regression: pass");
    end else begin
      $display("bitmap_pool_allocator regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bpa_pkg.sv
hw/rtl/bitmap_pool_allocator.sv
verif/bpa_tb_pkg.sv
verif/bitmap_pool_allocator_chk.sv
verif/bitmap_pool_allocator_tb.sv
